// ----- rtl/core/bals_pkg.sv -----
// Package for the bounded sorted-insert array list: sizes, mode and status codes,
// sequencer states and the RAM request bundle.
// Used by bals_ram and by the top level; depends on nothing.
package bals_pkg;

    // Storage size and derived widths.
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the transaction ports.
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Common width for comparing a position against the entry count.
    localparam int WIDE_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SORTED  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_WAIT,
        S_SCAN,
        S_SHIFT,
        S_PUT,
        S_REV_J,
        S_REV_WI,
        S_REV_WJ
    } state_t;

    // One write port and one read port of the entry memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

// ----- rtl/core/bounded_array_list_sorted_insert.sv -----
// Top level of the bounded array list with sorted insert: sequencer, count and result register.
// Depends on bals_pkg and bals_ram.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid / in_stall  mode, value, position
//   output    out        out_valid/out_stall  read_value, status, count
//
// One request is worked on at a time; each gives one result transaction.
// Append, errors, insert at position count, sorted insert into an empty list and reverse of
// fewer than two entries finish in the accept cycle; a read waits in S_READ_WAIT for its data.
// Insert at p below count moves the tail up one entry at a time in S_SHIFT, then writes in S_PUT.
// Sorted insert scans in S_SCAN, then goes through S_SHIFT (unless it lands at the end) and S_PUT.
// Reverse swaps each pair in S_REV_J, S_REV_WI and S_REV_WJ; the single memory ports set these steps.
// Reset clears the count and the result valid flag; the result payload and the memory have no reset.
// A new request is taken in idle while the result register is empty or being taken.
module bounded_array_list_sorted_insert
    import bals_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [MODE_W-1:0]          mode,
    input  logic signed [DATA_W-1:0]   value,
    input  logic [POS_W-1:0]           position,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [DATA_W-1:0]   read_value,
    output logic [STATUS_W-1:0]        status,
    output logic [COUNT_W-1:0]         count
);

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          lo_reg, lo_next;
    logic [CNT_W-1:0]          hi_reg, hi_next;
    logic signed [DATA_W-1:0]  value_reg, value_next;
    logic [DATA_W-1:0]         tmp_reg, tmp_next;

    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  read_value_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [CNT_W-1:0]          out_count_reg;

    logic                      emit;
    logic [DATA_W-1:0]         emit_rd;
    logic [STATUS_W-1:0]       emit_st;

    ram_req_t                  ram_req;
    logic [DATA_W-1:0]         ram_rdata;

    logic                      take_in;
    logic                      full;
    logic [WIDE_W-1:0]         pos_w;
    logic [WIDE_W-1:0]         cnt_w;
    logic                      pos_gt;
    logic                      pos_ge;
    logic                      pos_eq;
    logic                      cnt_empty;
    logic                      cnt_small;
    logic                      scan_hit;
    logic                      scan_last;
    logic                      shift_last;
    logic                      rev_more;

    bals_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Handshake: a request enters only in idle with room in the result register.
    assign in_stall = !((state_reg == S_IDLE) && (!out_valid_reg || !out_stall));
    assign take_in  = in_valid && !in_stall;

    // Decode flags shared by the next-state and output logic.
    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign pos_w      = WIDE_W'(position);
    assign cnt_w      = WIDE_W'(count_reg);
    assign pos_gt     = (pos_w > cnt_w);
    assign pos_ge     = (pos_w >= cnt_w);
    assign pos_eq     = (pos_w == cnt_w);
    assign cnt_empty  = (count_reg == '0);
    assign cnt_small  = (count_reg < CNT_W'(2));
    assign scan_hit   = ($signed(ram_rdata) >= value_reg);
    assign scan_last  = ((lo_reg + 1'b1) == count_reg);
    assign shift_last = ((hi_reg - 1'b1) == lo_reg);
    assign rev_more   = (({1'b0, lo_reg} + (CNT_W + 1)'(2)) < {1'b0, hi_reg});

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take_in)
                begin
                    case (mode)
                        MODE_INSERT:
                        begin
                            if (!pos_gt && !full && !pos_eq)
                            begin
                                state_next = S_SHIFT;
                            end
                        end
                        MODE_SORTED:
                        begin
                            if (!full && !cnt_empty)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        MODE_READ:
                        begin
                            if (!pos_ge)
                            begin
                                state_next = S_READ_WAIT;
                            end
                        end
                        MODE_REVERSE:
                        begin
                            if (!cnt_small)
                            begin
                                state_next = S_REV_J;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ_WAIT:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = S_SHIFT;
                end
                else if (scan_last)
                begin
                    state_next = S_PUT;
                end
            end
            S_SHIFT:
            begin
                if (shift_last)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                state_next = S_IDLE;
            end
            S_REV_J:
            begin
                state_next = S_REV_WI;
            end
            S_REV_WI:
            begin
                state_next = S_REV_WJ;
            end
            S_REV_WJ:
            begin
                state_next = rev_more ? S_REV_J : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory accesses, working registers and result of each state.
    always_comb
    begin
        ram_req    = '0;
        emit       = 1'b0;
        emit_rd    = '0;
        emit_st    = STAT_OK;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        value_next = value_reg;
        tmp_next   = tmp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take_in)
                begin
                    value_next = value;
                    case (mode)
                        MODE_APPEND:
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                emit_st = STAT_FULL;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = ADDR_W'(count_reg);
                                ram_req.wdata = value;
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (pos_gt)
                            begin
                                emit    = 1'b1;
                                emit_st = STAT_RANGE;
                            end
                            else if (full)
                            begin
                                emit    = 1'b1;
                                emit_st = STAT_FULL;
                            end
                            else if (pos_eq)
                            begin
                                emit          = 1'b1;
                                ram_req.we    = 1'b1;
                                ram_req.waddr = ADDR_W'(count_reg);
                                ram_req.wdata = value;
                                count_next    = count_reg + 1'b1;
                            end
                            else
                            begin
                                // Start moving the tail up from the last entry.
                                ram_req.re    = 1'b1;
                                ram_req.raddr = ADDR_W'(count_reg - 1'b1);
                                hi_next       = count_reg;
                                lo_next       = CNT_W'(position);
                            end
                        end
                        MODE_SORTED:
                        begin
                            if (full)
                            begin
                                emit    = 1'b1;
                                emit_st = STAT_FULL;
                            end
                            else if (cnt_empty)
                            begin
                                emit          = 1'b1;
                                ram_req.we    = 1'b1;
                                ram_req.waddr = '0;
                                ram_req.wdata = value;
                                count_next    = count_reg + 1'b1;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = '0;
                                lo_next       = '0;
                            end
                        end
                        MODE_READ:
                        begin
                            if (pos_ge)
                            begin
                                emit    = 1'b1;
                                emit_st = STAT_RANGE;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = ADDR_W'(position);
                            end
                        end
                        MODE_REVERSE:
                        begin
                            if (cnt_small)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = '0;
                                lo_next       = '0;
                                hi_next       = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_READ_WAIT:
            begin
                emit    = 1'b1;
                emit_rd = ram_rdata;
            end
            S_SCAN:
            begin
                // The entry at lo_reg is on the read port.
                if (scan_hit)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ADDR_W'(count_reg - 1'b1);
                    hi_next       = count_reg;
                end
                else if (scan_last)
                begin
                    lo_next = count_reg;
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ADDR_W'(lo_reg + 1'b1);
                    lo_next       = lo_reg + 1'b1;
                end
            end
            S_SHIFT:
            begin
                // Entry hi_reg - 1 arrives and moves to hi_reg; unless this is the last move, the next one is fetched.
                ram_req.we    = 1'b1;
                ram_req.waddr = ADDR_W'(hi_reg);
                ram_req.wdata = ram_rdata;
                if (!shift_last)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ADDR_W'(hi_reg - CNT_W'(2));
                    hi_next       = hi_reg - 1'b1;
                end
            end
            S_PUT:
            begin
                emit          = 1'b1;
                ram_req.we    = 1'b1;
                ram_req.waddr = ADDR_W'(lo_reg);
                ram_req.wdata = value_reg;
                count_next    = count_reg + 1'b1;
            end
            S_REV_J:
            begin
                tmp_next      = ram_rdata;
                ram_req.re    = 1'b1;
                ram_req.raddr = ADDR_W'(hi_reg);
            end
            S_REV_WI:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ADDR_W'(lo_reg);
                ram_req.wdata = ram_rdata;
            end
            S_REV_WJ:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ADDR_W'(hi_reg);
                ram_req.wdata = tmp_reg;
                if (rev_more)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ADDR_W'(lo_reg + 1'b1);
                    lo_next       = lo_reg + 1'b1;
                    hi_next       = hi_reg - 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and result payload.
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        value_reg <= value_next;
        tmp_reg   <= tmp_next;
        if (emit)
        begin
            read_value_reg <= emit_rd;
            status_reg     <= emit_st;
            out_count_reg  <= count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign count      = COUNT_W'(out_count_reg);

endmodule

// ----- rtl/core/bals_ram.sv -----
// Entry memory of the list: one write port, one read port, registered read data.
// Depends on bals_pkg for sizes and the request bundle.
module bals_ram
    import bals_pkg::*;
(
    input  logic              clk,
    input  ram_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [CAPACITY];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule
